// ----- rtl/mpq_pkg.sv -----
package mpq_pkg;

  localparam int unsigned FieldTagW = 16;
  localparam int unsigned FieldLvlW = 3;

  typedef enum logic {
    OP_ENQ = 1'b0,
    OP_DEQ = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_EMPTY   = 2'd2,
    ST_BAD_PRI = 2'd3
  } status_e;

  typedef struct packed {
    status_e                status;
    logic [FieldLvlW-1:0]   level;
    logic                   all_empty;
    logic                   deq_ok;
  } resp_t;

endpackage

// ----- rtl/mpq_store.sv -----
module mpq_store #(
  parameter int unsigned ADDR_W = 6,
  parameter int unsigned DATA_W = 16
) (
  input  logic              clk_i,
  input  logic              wr_en_i,
  input  logic [ADDR_W-1:0] wr_addr_i,
  input  logic [DATA_W-1:0] wr_data_i,
  input  logic              rd_en_i,
  input  logic [ADDR_W-1:0] rd_addr_i,
  output logic [DATA_W-1:0] rd_data_o
);

  localparam int unsigned Depth = 1 << ADDR_W;

  logic [DATA_W-1:0] mem [Depth];
  logic [DATA_W-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ----- rtl/mpq_ctrl.sv -----
module mpq_ctrl #(
  parameter int unsigned NUM_LEVELS  = 4,
  parameter int unsigned LEVEL_DEPTH = 16,
  parameter int unsigned ADDR_W      = 6
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               accept_i,
  input  mpq_pkg::op_e                       op_i,
  input  logic [mpq_pkg::FieldLvlW-1:0]      level_i,
  output logic                               wr_en_o,
  output logic [ADDR_W-1:0]                  wr_addr_o,
  output logic                               rd_en_o,
  output logic [ADDR_W-1:0]                  rd_addr_o,
  output logic                               resp_valid_o,
  output mpq_pkg::resp_t                     resp_o
);

  import mpq_pkg::*;

  localparam int unsigned LvlW = (NUM_LEVELS > 1) ? $clog2(NUM_LEVELS) : 1;
  localparam int unsigned PtrW = $clog2(LEVEL_DEPTH);
  localparam int unsigned CntW = $clog2(LEVEL_DEPTH + 1);

  logic [CntW-1:0] count_q [NUM_LEVELS];
  logic [CntW-1:0] count_d [NUM_LEVELS];
  logic [PtrW-1:0] head_q  [NUM_LEVELS];
  logic [PtrW-1:0] head_d  [NUM_LEVELS];

  logic                 resp_valid_q;
  resp_t                resp_q;
  resp_t                resp_d;

  logic                 lvl_ok;
  logic [FieldLvlW-1:0] lvl_m1;
  logic [LvlW-1:0]      enq_idx;
  logic                 enq_full;
  logic [PtrW:0]        slot_sum;
  logic [PtrW-1:0]      enq_slot;
  logic                 any_held;
  logic [LvlW-1:0]      deq_idx;
  logic [PtrW-1:0]      deq_head;
  logic                 empty_after;

  always_comb begin
    lvl_m1   = level_i - FieldLvlW'(1);
    lvl_ok   = (level_i != '0) && (32'(level_i) <= NUM_LEVELS);
    enq_idx  = LvlW'(32'(lvl_m1));
    enq_full = 32'(count_q[enq_idx]) >= LEVEL_DEPTH;
    slot_sum = (PtrW + 1)'(32'(head_q[enq_idx]) + 32'(count_q[enq_idx]));
    if (32'(slot_sum) >= LEVEL_DEPTH) begin
      enq_slot = PtrW'(32'(slot_sum) - LEVEL_DEPTH);
    end else begin
      enq_slot = slot_sum[PtrW-1:0];
    end
  end

  // highest non-empty level
  always_comb begin
    any_held = 1'b0;
    deq_idx  = '0;
    for (int i = 0; i < NUM_LEVELS; i++) begin
      if (count_q[i] != '0) begin
        any_held = 1'b1;
        deq_idx  = LvlW'(i);
      end
    end
    deq_head = head_q[deq_idx];
  end

  always_comb begin
    for (int i = 0; i < NUM_LEVELS; i++) begin
      count_d[i] = count_q[i];
      head_d[i]  = head_q[i];
    end
    wr_en_o   = 1'b0;
    rd_en_o   = 1'b0;
    wr_addr_o = ADDR_W'({enq_idx, enq_slot});
    rd_addr_o = ADDR_W'({deq_idx, deq_head});
    resp_d    = '{status: ST_OK, level: '0, all_empty: 1'b0, deq_ok: 1'b0};

    case (op_i)
      OP_ENQ: begin
        if (!lvl_ok) begin
          resp_d.status = ST_BAD_PRI;
        end else if (enq_full) begin
          resp_d.status = ST_FULL;
        end else begin
          wr_en_o          = accept_i;
          count_d[enq_idx] = count_q[enq_idx] + CntW'(1);
        end
      end
      OP_DEQ: begin
        if (!any_held) begin
          resp_d.status = ST_EMPTY;
        end else begin
          rd_en_o          = accept_i;
          resp_d.deq_ok    = 1'b1;
          resp_d.level     = FieldLvlW'(32'(deq_idx) + 1);
          count_d[deq_idx] = count_q[deq_idx] - CntW'(1);
          if (32'(deq_head) == LEVEL_DEPTH - 1) begin
            head_d[deq_idx] = '0;
          end else begin
            head_d[deq_idx] = deq_head + PtrW'(1);
          end
        end
      end
      default: begin
        resp_d.status = ST_OK;
      end
    endcase

    empty_after = 1'b1;
    for (int i = 0; i < NUM_LEVELS; i++) begin
      if (count_d[i] != '0) begin
        empty_after = 1'b0;
      end
    end
    resp_d.all_empty = empty_after;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      resp_valid_q <= 1'b0;
      for (int i = 0; i < NUM_LEVELS; i++) begin
        count_q[i] <= '0;
        head_q[i]  <= '0;
      end
    end else begin
      resp_valid_q <= accept_i;
      if (accept_i) begin
        for (int i = 0; i < NUM_LEVELS; i++) begin
          count_q[i] <= count_d[i];
          head_q[i]  <= head_d[i];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      resp_q <= resp_d;
    end
  end

  assign resp_valid_o = resp_valid_q;
  assign resp_o       = resp_q;

endmodule

// ----- rtl/multilevel_priority_queue_unit.sv -----
// channel   direction  ports                                   beat marker
// command   in         op_i, level_i, entry_tag_i              start_i && !busy_o
// result    out        status_o, out_tag_o, out_level_o,       done_o
//                      all_empty_o
//
// one beat per cycle: busy_o stays low and a command may follow in the next cycle
// the result of a beat shows on done_o in the cycle after it is taken
// counts and heads sit in flops, tags in a memory with a registered read port
// reset clears every level count and head; stored tags need no clearing
// the receiver cannot stall: each result stands for exactly one cycle
module multilevel_priority_queue_unit #(
  parameter int unsigned NUM_LEVELS  = 4,
  parameter int unsigned LEVEL_DEPTH = 16,
  parameter int unsigned TAG_BITS    = 16
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start_i,
  output logic                               busy_o,
  input  logic                               op_i,
  input  logic [mpq_pkg::FieldLvlW-1:0]      level_i,
  input  logic [mpq_pkg::FieldTagW-1:0]      entry_tag_i,
  output logic                               done_o,
  output logic [1:0]                         status_o,
  output logic [mpq_pkg::FieldTagW-1:0]      out_tag_o,
  output logic [mpq_pkg::FieldLvlW-1:0]      out_level_o,
  output logic                               all_empty_o
);

  import mpq_pkg::*;

  localparam int unsigned LvlW  = (NUM_LEVELS > 1) ? $clog2(NUM_LEVELS) : 1;
  localparam int unsigned PtrW  = $clog2(LEVEL_DEPTH);
  localparam int unsigned AddrW = LvlW + PtrW;

  logic                accept;
  logic                wr_en;
  logic [AddrW-1:0]    wr_addr;
  logic                rd_en;
  logic [AddrW-1:0]    rd_addr;
  logic [TAG_BITS-1:0] rd_data;
  logic                resp_valid;
  resp_t               resp;
  op_e                 op;

  assign busy_o = 1'b0;
  assign accept = start_i && !busy_o;
  assign op     = op_e'(op_i);

  mpq_ctrl #(
    .NUM_LEVELS  (NUM_LEVELS),
    .LEVEL_DEPTH (LEVEL_DEPTH),
    .ADDR_W      (AddrW)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (accept),
    .op_i         (op),
    .level_i      (level_i),
    .wr_en_o      (wr_en),
    .wr_addr_o    (wr_addr),
    .rd_en_o      (rd_en),
    .rd_addr_o    (rd_addr),
    .resp_valid_o (resp_valid),
    .resp_o       (resp)
  );

  mpq_store #(
    .ADDR_W (AddrW),
    .DATA_W (TAG_BITS)
  ) u_store (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (TAG_BITS'(entry_tag_i)),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  assign done_o      = resp_valid;
  assign status_o    = resp.status;
  assign out_level_o = resp.level;
  assign all_empty_o = resp.all_empty;
  assign out_tag_o   = resp.deq_ok ? FieldTagW'(rd_data) : '0;

endmodule

// ----- tb/sv/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;
  import mpq_pkg::*;

  localparam int unsigned NumLevels  = 4;
  localparam int unsigned LevelDepth = 16;
  localparam int unsigned TagBits    = 16;
  localparam int unsigned StallLimit = 1000;
  localparam int unsigned DrainWait  = 4;

  typedef struct {
    op_e                  op;
    logic [FieldLvlW-1:0] level;
    logic [FieldTagW-1:0] tag;
    int unsigned          gap;
  } cmd_t;

  typedef struct {
    status_e              status;
    logic [FieldTagW-1:0] tag;
    logic [FieldLvlW-1:0] level;
    logic                 all_empty;
  } answer_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 start_i = 1'b0;
  logic                 busy_o;
  logic                 op_i = 1'b0;
  logic [FieldLvlW-1:0] level_i = '0;
  logic [FieldTagW-1:0] entry_tag_i = '0;
  logic                 done_o;
  logic [1:0]           status_o;
  logic [FieldTagW-1:0] out_tag_o;
  logic [FieldLvlW-1:0] out_level_o;
  logic                 all_empty_o;

  cmd_t                 pending_cmds[$];
  answer_t              expected_answers[$];
  logic [FieldTagW-1:0] level_fifo[NumLevels][$];
  int unsigned          idle_cnt = 0;
  int unsigned          stall_cnt = 0;
  int unsigned          cmds_taken = 0;
  int unsigned          answers_seen = 0;
  int unsigned          status_hits[4] = '{0, 0, 0, 0};
  int unsigned          error_cnt = 0;

  multilevel_priority_queue_unit #(
    .NUM_LEVELS (NumLevels),
    .LEVEL_DEPTH(LevelDepth),
    .TAG_BITS   (TagBits)
  ) DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_i),
    .busy_o     (busy_o),
    .op_i       (op_i),
    .level_i    (level_i),
    .entry_tag_i(entry_tag_i),
    .done_o     (done_o),
    .status_o   (status_o),
    .out_tag_o  (out_tag_o),
    .out_level_o(out_level_o),
    .all_empty_o(all_empty_o)
  );

  always #6 clk_i = ~clk_i;

  function automatic logic queue_is_empty();
    for (int i = 0; i < NumLevels; i++) begin
      if (level_fifo[i].size() != 0) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic answer_t serve_command(logic op, logic [FieldLvlW-1:0] lvl,
                                            logic [FieldTagW-1:0] tag);
    answer_t ans;
    int      idx;
    ans.status = ST_OK;
    ans.tag    = '0;
    ans.level  = '0;
    if (op == OP_ENQ) begin
      if (lvl < 1 || lvl > NumLevels) begin
        ans.status = ST_BAD_PRI;
      end else if (level_fifo[lvl-1].size() >= LevelDepth) begin
        ans.status = ST_FULL;
      end else begin
        level_fifo[lvl-1].push_back(tag);
      end
    end else begin
      idx = -1;
      for (int i = NumLevels - 1; i >= 0; i--) begin
        if (idx < 0 && level_fifo[i].size() != 0) idx = i;
      end
      if (idx < 0) begin
        ans.status = ST_EMPTY;
      end else begin
        ans.tag   = level_fifo[idx].pop_front();
        ans.level = FieldLvlW'(idx + 1);
      end
    end
    ans.all_empty = queue_is_empty();
    return ans;
  endfunction

  // driver
  always @(posedge clk_i or negedge rst_ni) begin
    cmd_t nxt;
    if (!rst_ni) begin
      start_i     <= 1'b0;
      op_i        <= 1'b0;
      level_i     <= '0;
      entry_tag_i <= '0;
      idle_cnt    <= 0;
    end else begin
      if (start_i && !busy_o) begin
        expected_answers.push_back(serve_command(op_i, level_i, entry_tag_i));
        cmds_taken <= cmds_taken + 1;
      end
      if (!start_i || !busy_o) begin
        if (pending_cmds.size() == 0) begin
          start_i <= 1'b0;
        end else if (idle_cnt < pending_cmds[0].gap) begin
          start_i  <= 1'b0;
          idle_cnt <= idle_cnt + 1;
        end else begin
          nxt         = pending_cmds.pop_front();
          start_i     <= 1'b1;
          op_i        <= nxt.op;
          level_i     <= nxt.level;
          entry_tag_i <= nxt.tag;
          idle_cnt    <= 0;
        end
      end
    end
  end

  task automatic check_field(string name, int unsigned exp_val, int unsigned act_val);
    if (exp_val != act_val) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_val, act_val);
      error_cnt++;
    end
  endtask

  // monitor and watchdog
  always @(posedge clk_i) begin
    answer_t exp_ans;
    if (rst_ni) begin
      if (done_o) begin
        answers_seen++;
        status_hits[status_o]++;
        if (expected_answers.size() == 0) begin
          $display("%0t: unexpected result beat, status %0d tag %0h level %0d", $time,
                   status_o, out_tag_o, out_level_o);
          error_cnt++;
        end else begin
          exp_ans = expected_answers.pop_front();
          check_field("status", exp_ans.status, status_o);
          check_field("out_tag", exp_ans.tag, out_tag_o);
          check_field("out_level", exp_ans.level, out_level_o);
          check_field("all_empty", exp_ans.all_empty, all_empty_o);
        end
      end
      if ((start_i && !busy_o) || done_o) begin
        stall_cnt <= 0;
      end else if (stall_cnt + 1 >= StallLimit) begin
        $display("%0t: timeout, no beat for %0d cycles", $time, StallLimit);
        $display("Testbench completed WITH ERRORS");
        $finish;
      end else begin
        stall_cnt <= stall_cnt + 1;
      end
    end
  end

  task automatic add_cmd(op_e op, int unsigned lvl, int unsigned tag, int unsigned gap);
    cmd_t c;
    c.op    = op;
    c.level = FieldLvlW'(lvl);
    c.tag   = FieldTagW'(tag);
    c.gap   = gap;
    pending_cmds.push_back(c);
  endtask

  task automatic add_random_cmd(int unsigned enq_pct, int focus, int unsigned gap);
    int unsigned lvl;
    int unsigned pick;
    if ($urandom_range(0, 99) < 8) begin
      pick = $urandom_range(0, 3);
      lvl  = (pick == 0) ? 0 : pick + 4;
    end else if (focus >= 0 && $urandom_range(0, 99) < 85) begin
      lvl = focus;
    end else begin
      lvl = $urandom_range(1, NumLevels);
    end
    add_cmd(($urandom_range(0, 99) < enq_pct) ? OP_ENQ : OP_DEQ, lvl,
            $urandom_range(0, 16'hffff), gap);
  endtask

  initial begin
    int unsigned enq_pct;
    int          focus;
    bit          gaps_on;

    // directed beats
    add_cmd(OP_DEQ, 0, 16'h0000, 0);
    add_cmd(OP_ENQ, 0, 16'h1234, 0);
    add_cmd(OP_ENQ, 5, 16'h4321, 1);
    add_cmd(OP_ENQ, 7, 16'hffff, 0);
    add_cmd(OP_ENQ, 1, 16'h0000, 0);
    add_cmd(OP_ENQ, 4, 16'hffff, 2);
    add_cmd(OP_ENQ, 3, 16'h5555, 0);
    add_cmd(OP_ENQ, 2, 16'haaaa, 0);
    add_cmd(OP_ENQ, 4, 16'h0001, 0);
    add_cmd(OP_DEQ, 7, 16'hffff, 0);
    add_cmd(OP_DEQ, 0, 16'h0000, 3);
    add_cmd(OP_DEQ, 2, 16'h8000, 0);
    add_cmd(OP_DEQ, 1, 16'h7fff, 0);
    add_cmd(OP_DEQ, 4, 16'h0000, 0);
    add_cmd(OP_DEQ, 3, 16'h0000, 0);

    // random phases, some hammering one level to overflow and wrap its ring
    for (int blk = 0; blk < 20; blk++) begin
      case ($urandom_range(0, 3))
        0: enq_pct = 10;
        1: enq_pct = 50;
        2: enq_pct = 85;
        default: enq_pct = 100;
      endcase
      focus   = ($urandom_range(0, 1) == 0) ? -1 : int'($urandom_range(1, NumLevels));
      gaps_on = ($urandom_range(0, 2) != 0);
      for (int k = 0; k < 35; k++) begin
        add_random_cmd(enq_pct, focus, gaps_on ? $urandom_range(0, 8) : 0);
      end
    end

    repeat (2) @(posedge clk_i);
    @(negedge clk_i) rst_ni = 1'b1;

    while (pending_cmds.size() != 0 || start_i || expected_answers.size() != 0) begin
      @(negedge clk_i);
    end
    repeat (DrainWait) @(negedge clk_i);
    if (expected_answers.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, expected_answers.size());
      error_cnt++;
    end

    $display("commands issued %0d, results checked %0d", cmds_taken, answers_seen);
    $display("status counts: ok %0d, full %0d, empty %0d, bad priority %0d",
             status_hits[ST_OK], status_hits[ST_FULL], status_hits[ST_EMPTY],
             status_hits[ST_BAD_PRI]);
    if (error_cnt == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
